// ----- hdl/btla_pkg.sv -----
// shared constants, types and codes of the ticket lock arbiter
package btla_pkg;

   localparam int MAX_THREADS   = 16;
   localparam int TICKET_BITS   = 16;
   localparam int THREAD_BITS   = 4;
   localparam int COUNT_BITS    = 5;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [TICKET_BITS-1:0] ticket_type;
   typedef logic [THREAD_BITS-1:0] thread_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [1:0]             status_type;

   // operation codes
   localparam logic OP_LOCK    = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // result status codes
   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_INACTIVE = 2'd1;
   localparam status_type STATUS_OVERFLOW = 2'd2;

   // register select (word address bit) and reset value
   localparam logic      CSR_SEL_ACTIVE = 1'b0;
   localparam count_type ACTIVE_RESET   = count_type'(MAX_THREADS);

   // commands from controller to datapath
   typedef struct packed {
      logic start;
      logic step;
      logic finish;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic scan_last;
      logic out_free;
   } dp_sts_type;

endpackage

// ----- hdl/btla_if.sv -----
// handshake channels for request and response beats
interface btla_req_if;
   logic                  valid;
   logic                  ready;
   logic                  operation;
   btla_pkg::thread_type  thread_index;

   modport source (output valid, output operation, output thread_index, input ready);
   modport sink   (input valid, input operation, input thread_index, output ready);
endinterface

interface btla_rsp_if;
   logic                  valid;
   logic                  ready;
   logic                  holder_valid;
   btla_pkg::thread_type  holder_index;
   btla_pkg::ticket_type  assigned_ticket;
   btla_pkg::status_type  status;

   modport source (output valid, output holder_valid, output holder_index,
                   output assigned_ticket, output status, input ready);
   modport sink   (input valid, input holder_valid, input holder_index,
                   input assigned_ticket, input status, output ready);
endinterface

// ----- hdl/bakery_ticket_lock_arbiter.sv -----
// Ticket lock arbiter: a granted lock beat gives its thread a ticket one above the largest
// ticket among the active threads, a release beat clears it, and every beat returns one
// response beat naming the holder (lowest nonzero ticket, lower index on a tie), the ticket
// granted and a status. A beat is accepted in the idle state, then the scan walks the
// ticket store over the active threads, reading one entry a cycle, and after the
// last entry the controller moves to the finish state, where it goes on to update
// the store and load the response register. The response register lets the next request
// beat be accepted and scanned while an earlier response still waits to be taken; if that
// response is still waiting when the scan ends, the update cycle waits until it is taken.
module bakery_ticket_lock_arbiter (
   input  logic                                  clock,
   input  logic                                  reset,
   btla_req_if.sink                              req_bus,
   btla_rsp_if.source                            rsp_bus,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [btla_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [btla_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [btla_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import btla_pkg::*;

   count_type  live_count;
   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       ready_w;

   assign req_bus.ready = ready_w;

   // configuration register
   btla_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .live_count  (live_count)
   );

   // sequencer
   btla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ready_w),
      .cmd       (cmd),
      .sts       (sts)
   );

   // ticket store and scan
   btla_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .live_count       (live_count),
      .req_operation    (req_bus.operation),
      .req_thread_index (req_bus.thread_index),
      .rsp_bus          (rsp_bus)
   );

endmodule

// ----- hdl/btla_csr.sv -----
// apb register holding the active thread count
module btla_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [btla_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [btla_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [btla_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready,
   output btla_pkg::count_type                   live_count
);
   import btla_pkg::*;

   count_type active_ff;
   count_type active_in;
   logic      sel_active;
   logic      wr_en;

   assign sel_active = (csr_paddr[2] == CSR_SEL_ACTIVE);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && sel_active;
   assign csr_pready = 1'b1;

   // register write
   always_comb begin
      active_in = active_ff;
      if (wr_en) begin
         active_in = csr_pwdata[COUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else begin
         active_ff <= active_in;
      end
   end

   // read back
   assign csr_prdata = sel_active ? CSR_DATA_BITS'(active_ff) : '0;

   // zero acts as one, above the thread count acts as the thread count
   always_comb begin
      priority if (active_ff == '0) begin
         live_count = count_type'(1);
      end else if (active_ff > count_type'(MAX_THREADS)) begin
         live_count = count_type'(MAX_THREADS);
      end else begin
         live_count = active_ff;
      end
   end

endmodule

// ----- hdl/btla_dp.sv -----
// ticket store, scan unit and response register
module btla_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  btla_pkg::dp_cmd_type   cmd,
   output btla_pkg::dp_sts_type   sts,
   input  btla_pkg::count_type    live_count,
   input  logic                   req_operation,
   input  btla_pkg::thread_type   req_thread_index,
   btla_rsp_if.source             rsp_bus
);
   import btla_pkg::*;

   localparam ticket_type TICKET_MAX = '1;

   // ticket store, one entry per thread
   logic [MAX_THREADS-1:0][TICKET_BITS-1:0] ticket_ff;
   logic [MAX_THREADS-1:0][TICKET_BITS-1:0] ticket_in;

   // latched item
   logic       op_ff;
   thread_type who_ff;

   // scan state
   thread_type idx_ff,      idx_in;
   ticket_type max_ff,      max_in;
   logic       all_fnd_ff,  all_fnd_in;
   ticket_type all_min_ff,  all_min_in;
   thread_type all_idx_ff,  all_idx_in;
   logic       oth_fnd_ff,  oth_fnd_in;
   ticket_type oth_min_ff,  oth_min_in;
   thread_type oth_idx_ff,  oth_idx_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       hv_ff,  hv_in;
   thread_type hi_ff,  hi_in;
   ticket_type at_ff,  at_in;
   status_type st_ff,  st_in;

   ticket_type scan_t;
   ticket_type next_ticket;
   thread_type last_idx;
   logic       active_w;
   logic       overflow_w;
   logic       grant_ok;
   logic       release_ok;

   assign scan_t      = ticket_ff[idx_ff];
   assign next_ticket = max_ff + ticket_type'(1);
   assign last_idx    = thread_type'(live_count - count_type'(1));
   assign active_w    = ({1'b0, who_ff} < live_count);
   assign overflow_w  = (max_ff == TICKET_MAX);
   assign grant_ok    = active_w && (op_ff == OP_LOCK) && !overflow_w;
   assign release_ok  = active_w && (op_ff == OP_RELEASE);

   assign sts.scan_last = (idx_ff == last_idx);
   assign sts.out_free  = !rsp_valid_ff || rsp_bus.ready;

   // item latch
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= req_operation;
         who_ff <= req_thread_index;
      end
   end

   // scan: running max, lowest over all, lowest over the other threads
   always_comb begin
      idx_in     = idx_ff;
      max_in     = max_ff;
      all_fnd_in = all_fnd_ff;
      all_min_in = all_min_ff;
      all_idx_in = all_idx_ff;
      oth_fnd_in = oth_fnd_ff;
      oth_min_in = oth_min_ff;
      oth_idx_in = oth_idx_ff;
      if (cmd.start) begin
         idx_in     = '0;
         max_in     = '0;
         all_fnd_in = 1'b0;
         oth_fnd_in = 1'b0;
      end else if (cmd.step) begin
         idx_in = idx_ff + thread_type'(1);
         if (scan_t > max_ff) begin
            max_in = scan_t;
         end
         if (scan_t != '0 && (!all_fnd_ff || scan_t < all_min_ff)) begin
            all_fnd_in = 1'b1;
            all_min_in = scan_t;
            all_idx_in = idx_ff;
         end
         if (scan_t != '0 && idx_ff != who_ff && (!oth_fnd_ff || scan_t < oth_min_ff)) begin
            oth_fnd_in = 1'b1;
            oth_min_in = scan_t;
            oth_idx_in = idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      max_ff     <= max_in;
      all_min_ff <= all_min_in;
      all_idx_ff <= all_idx_in;
      oth_min_ff <= oth_min_in;
      oth_idx_ff <= oth_idx_in;
      if (reset) begin
         all_fnd_ff <= 1'b0;
         oth_fnd_ff <= 1'b0;
      end else begin
         all_fnd_ff <= all_fnd_in;
         oth_fnd_ff <= oth_fnd_in;
      end
   end

   // store update at finish
   always_comb begin
      ticket_in = ticket_ff;
      if (cmd.finish) begin
         if (grant_ok) begin
            ticket_in[who_ff] = next_ticket;
         end else if (release_ok) begin
            ticket_in[who_ff] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticket_ff <= '0;
      end else begin
         ticket_ff <= ticket_in;
      end
   end

   // result: a fresh grant is above every other ticket
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      hv_in        = hv_ff;
      hi_in        = hi_ff;
      at_in        = at_ff;
      st_in        = st_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         at_in        = '0;
         priority if (grant_ok) begin
            st_in = STATUS_OK;
            at_in = next_ticket;
            hv_in = 1'b1;
            hi_in = oth_fnd_ff ? oth_idx_ff : who_ff;
         end else if (release_ok) begin
            st_in = STATUS_OK;
            hv_in = oth_fnd_ff;
            hi_in = oth_fnd_ff ? oth_idx_ff : '0;
         end else begin
            st_in = active_w ? STATUS_OVERFLOW : STATUS_INACTIVE;
            hv_in = all_fnd_ff;
            hi_in = all_fnd_ff ? all_idx_ff : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      hv_ff <= hv_in;
      hi_ff <= hi_in;
      at_ff <= at_in;
      st_ff <= st_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.holder_valid    = hv_ff;
   assign rsp_bus.holder_index    = hi_ff;
   assign rsp_bus.assigned_ticket = at_ff;
   assign rsp_bus.status          = st_ff;

   // a grant lands in the requesting thread's entry
   a_grant_written: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && grant_ok |=> ticket_ff[who_ff] == ticket_type'($past(max_ff) + 1'b1))
      else $error("granted ticket not stored");

   // refused items leave the store alone
   a_refused_no_change: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && !grant_ok && !release_ok |=> ticket_ff == $past(ticket_ff))
      else $error("refused item changed the ticket store");

   // a granted ticket always leaves a holder
   a_grant_has_holder: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && at_ff != '0 |-> hv_ff && st_ff == STATUS_OK)
      else $error("grant reported without holder");

endmodule

// ----- hdl/btla_ctrl.sv -----
// controller: accept, scan, finish sequence
module btla_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output btla_pkg::dp_cmd_type   cmd,
   input  btla_pkg::dp_sts_type   sts
);
   import btla_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // never overwrite a waiting response
   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> sts.out_free)
      else $error("finish issued while response register busy");

   // a scan always follows an accepted beat
   a_start_then_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> cmd.step)
      else $error("accepted beat not scanned");

   // only one command at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.step, cmd.finish}))
      else $error("overlapping datapath commands");

endmodule
